// ===== rtl/bts_pkg.sv =====
package bts_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int WEIGHT_BITS_DEF = 8;

  // Fixed field widths
  localparam int ADDR_W  = 16;
  localparam int COMP_W  = 8;
  localparam int TEXEL_W = 3 * COMP_W;
  localparam int COORD_W = 16;
  localparam int FRAC_W  = 16;

  localparam logic [FRAC_W-1:0] HALF_Q16 = 16'h8000;

  // Work queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BILINEAR_ENABLE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic                  BILIN_RST  = 1'b1;

  // Input command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Kind of work handed from front to back
  typedef enum logic [1:0] {
    K_WRITE = 2'b00,
    K_NEAR  = 2'b01,
    K_BLEND = 2'b10
  } kind_t;

endpackage

// ===== rtl/bts_in_if.sv =====
interface bts_in_if;
  import bts_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [ADDR_W-1:0]  texel_address;
  logic [COMP_W-1:0]  red_in;
  logic [COMP_W-1:0]  green_in;
  logic [COMP_W-1:0]  blue_in;
  logic [COORD_W-1:0] u_coord;
  logic [COORD_W-1:0] v_coord;

  modport source (
    output valid, command, texel_address, red_in, green_in, blue_in, u_coord, v_coord,
    input  ready
  );

  modport sink (
    input  valid, command, texel_address, red_in, green_in, blue_in, u_coord, v_coord,
    output ready
  );

endinterface

// ===== rtl/bts_out_if.sv =====
interface bts_out_if;
  import bts_pkg::*;

  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red_out;
  logic [COMP_W-1:0] green_out;
  logic [COMP_W-1:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );

endinterface

// ===== rtl/bilinear_texture_sampler_unit.sv =====
// Channel    Dir  Handshake      Carries
// in_chan    in   valid/ready    command, texel_address, red/green/blue_in, u/v_coord
// out_chan   out  valid/ready    red_out, green_out, blue_out (one per sample)
// cfg_*      in   cfg_we only    cfg_index, cfg_data (width, height, bilinear_enable)
//
// RAM: one port; a blend reads once per corner, a nearest sample or texel write
//   makes a single access. Samples may overlap in 2 output slots; a sample runs
//   through front stages, queue, RAM read, accumulator and output buffer.
// Reset: sync, active low, control only; texels undefined until written.
// Stalls: 4-entry queue between front and RAM sequencer; a sample starts only
//   once one of 2 output slots is reserved, so backpressure never drops data.
module bilinear_texture_sampler_unit #(
  parameter int MAX_WIDTH   = bts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bts_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bts_in_if.sink                         in_chan,
  bts_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bts_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  // queue entry: kind, address, row stride, two weights, write texel
  localparam int QW    = 2 + AW + WW + 2 * WEIGHT_BITS + TEXEL_W;

  // configuration registers
  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic                  bilin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      bilin_r  <= BILIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXTURE_WIDTH:   width_r  <= cfg_data;
        CFG_TEXTURE_HEIGHT:  height_r <= cfg_data;
        CFG_BILINEAR_ENABLE: bilin_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  logic          q_push, q_full, q_pop, q_valid;
  logic [QW-1:0] q_wdata, q_rdata;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [TEXEL_W-1:0] ram_wdata, ram_rdata;

  // front: scale, classify, compute texel address
  bts_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .QW          (QW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .cfg_width    (width_r),
    .cfg_height   (height_r),
    .cfg_bilinear (bilin_r),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  bts_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  // back: RAM sequencer, weighted sum, rounding, output buffer
  bts_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .QW          (QW),
    .AW          (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_chan  (out_chan)
  );

  // texel store, red 23:16, green 15:8, blue 7:0
  bts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (DEPTH)
  ) u_texels (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/bts_ram.sv =====
module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/bts_queue.sv =====
module bts_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = slot_r[rp_r];
  assign cnt_nxt   = cnt_r + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/bts_front.sv =====
module bts_front #(
  parameter int MAX_WIDTH   = bts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bts_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF,
  parameter int QW          = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bts_in_if.sink                          in_chan,
  input  logic [bts_pkg::CFG_DATA_W-1:0]  cfg_width,
  input  logic [bts_pkg::CFG_DATA_W-1:0]  cfg_height,
  input  logic                            cfg_bilinear,
  output logic                            q_push,
  output logic [QW-1:0]                   q_data,
  input  logic                            q_full
);

  import bts_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PUW   = COORD_W + WW;
  localparam int PVW   = COORD_W + HW;
  localparam int SW    = WW + HW + 1;
  localparam int WB    = WEIGHT_BITS;

  typedef struct packed {
    kind_t               kind;
    logic [AW-1:0]       addr;
    logic [WW-1:0]       w;
    logic [WB-1:0]       fu;
    logic [WB-1:0]       fv;
    logic [TEXEL_W-1:0]  texel;
  } q_entry_t;

  logic [WW-1:0] w_eff, w_m1;
  logic [HW-1:0] h_eff, h_m1;
  logic          en, take;

  // stage 1: scaled coordinates
  logic               s1_valid_r, s1_cmd_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [TEXEL_W-1:0] s1_texel_r;
  logic [PUW-1:0]     s1_pu_r;
  logic [PVW-1:0]     s1_pv_r;

  // stage 2: classified, texel position and weights
  logic [WW-1:0]  nu_raw, nu, x0;
  logic [HW-1:0]  nv_raw, nv, y0;
  logic [PUW-1:0] su;
  logic [PVW-1:0] sv;
  logic           border, wr_ok, keep2;
  kind_t          kind2;

  logic               s2_valid_r;
  kind_t              s2_kind_r;
  logic [WW-1:0]      s2_x_r;
  logic [HW-1:0]      s2_y_r;
  logic [WB-1:0]      s2_fu_r, s2_fv_r;
  logic [ADDR_W-1:0]  s2_addr_r;
  logic [TEXEL_W-1:0] s2_texel_r;

  // stage 3: linear address
  logic [SW-1:0] lin;
  q_entry_t      ent3;
  logic          s3_valid_r;
  q_entry_t      s3_entry_r;

  always_comb begin
    if (cfg_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height);
    end
  end

  assign w_m1 = w_eff - WW'(1);
  assign h_m1 = h_eff - HW'(1);

  assign en            = !s3_valid_r || !q_full;
  assign in_chan.ready = en;
  assign take          = in_chan.valid && en;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r   <= in_chan.command;
      s1_addr_r  <= in_chan.texel_address;
      s1_texel_r <= {in_chan.red_in, in_chan.green_in, in_chan.blue_in};
      s1_pu_r    <= PUW'(in_chan.u_coord) * PUW'(w_eff);
      s1_pv_r    <= PVW'(in_chan.v_coord) * PVW'(h_eff);
    end
  end

  always_comb begin
    nu_raw = s1_pu_r[PUW-1:FRAC_W];
    nv_raw = s1_pv_r[PVW-1:FRAC_W];
    nu     = (nu_raw > w_m1) ? w_m1 : nu_raw;
    nv     = (nv_raw > h_m1) ? h_m1 : nv_raw;
    border = !cfg_bilinear || (nu == '0) || (nu == w_m1) || (nv == '0) || (nv == h_m1);
    // half-texel shift; cannot wrap off the border
    su     = s1_pu_r - PUW'(HALF_Q16);
    sv     = s1_pv_r - PVW'(HALF_Q16);
    x0     = su[PUW-1:FRAC_W];
    y0     = sv[PVW-1:FRAC_W];
    wr_ok  = 32'(s1_addr_r) < DEPTH;
    if (s1_cmd_r == CMD_WRITE) begin
      kind2 = K_WRITE;
    end else if (border) begin
      kind2 = K_NEAR;
    end else begin
      kind2 = K_BLEND;
    end
    keep2 = s1_valid_r && ((s1_cmd_r == CMD_SAMPLE) || wr_ok);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r  <= kind2;
      s2_x_r     <= border ? nu : x0;
      s2_y_r     <= border ? nv : y0;
      s2_fu_r    <= border ? '0 : su[FRAC_W-1 -: WB];
      s2_fv_r    <= border ? '0 : sv[FRAC_W-1 -: WB];
      s2_addr_r  <= s1_addr_r;
      s2_texel_r <= s1_texel_r;
    end
  end

  always_comb begin
    lin        = SW'(s2_x_r) + SW'(w_eff) * SW'(s2_y_r);
    ent3.kind  = s2_kind_r;
    ent3.addr  = (s2_kind_r == K_WRITE) ? AW'(s2_addr_r) : AW'(lin);
    ent3.w     = w_eff;
    ent3.fu    = s2_fu_r;
    ent3.fv    = s2_fv_r;
    ent3.texel = s2_texel_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_entry_r <= ent3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= take;
      s2_valid_r <= keep2;
      s3_valid_r <= s2_valid_r;
    end
  end

  assign q_push = s3_valid_r && !q_full;
  assign q_data = s3_entry_r;

endmodule

// ===== rtl/bts_back.sv =====
module bts_back #(
  parameter int MAX_WIDTH   = bts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bts_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF,
  parameter int QW          = 64,
  parameter int AW          = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [QW-1:0]                q_data,
  output logic                         q_pop,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_addr,
  output logic [bts_pkg::TEXEL_W-1:0]  ram_wdata,
  input  logic [bts_pkg::TEXEL_W-1:0]  ram_rdata,
  bts_out_if.source                    out_chan
);

  import bts_pkg::*;

  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int WB        = WEIGHT_BITS;
  localparam int FW        = WB + 1;
  localparam int WTW       = 2 * WB + 1;
  localparam int ACW       = 2 * WB + 9;
  localparam int OUT_DEPTH = 2;
  localparam int OP_W      = $clog2(OUT_DEPTH);
  localparam int RSV_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [FW-1:0]  FULL = FW'(1) << WB;
  localparam logic [ACW-1:0] HALF = ACW'(1) << (2 * WB - 1);

  // corner order of the four blend reads
  localparam logic [1:0] STEP_TL = 2'd0;
  localparam logic [1:0] STEP_BL = 2'd1;
  localparam logic [1:0] STEP_TR = 2'd2;
  localparam logic [1:0] STEP_BR = 2'd3;

  typedef struct packed {
    kind_t               kind;
    logic [AW-1:0]       addr;
    logic [WW-1:0]       w;
    logic [WB-1:0]       fu;
    logic [WB-1:0]       fv;
    logic [TEXEL_W-1:0]  texel;
  } q_entry_t;

  q_entry_t   head, cur_r;
  logic       cur_valid_r;
  logic [1:0] k_r;

  logic [FW-1:0]   m1, m2;
  logic [2*FW-1:0] wt_prod;
  logic            is_wr, is_near, done, rd, head_smp, credit;

  // read tag, lines up with ram_rdata
  logic           t_valid_r, t_first_r, t_last_r;
  logic [WTW-1:0] t_wt_r;

  logic [ACW-1:0] prod    [3];
  logic [ACW-1:0] acc_nxt [3];
  logic [ACW-1:0] acc_r   [3];
  logic           done_r;

  logic [ACW-1:0]    rnd;
  logic [8:0]        val9;
  logic [TEXEL_W-1:0] res;

  logic [TEXEL_W-1:0] ofifo_r [OUT_DEPTH];
  logic [OP_W-1:0]    owp_r, orp_r;
  logic [RSV_W-1:0]   ocnt_r, ocnt_nxt, rsv_r, rsv_nxt;
  logic               out_xfer;

  assign head = q_data;

  // issue: one RAM access per cycle while an entry is current; samples wait for an output slot
  always_comb begin
    m1       = FULL - {1'b0, cur_r.fu};
    m2       = FULL - {1'b0, cur_r.fv};
    ram_addr = cur_r.addr;
    case (k_r)
      STEP_TL: begin
      end
      STEP_BL: begin
        ram_addr = cur_r.addr + AW'(cur_r.w);
        m2       = {1'b0, cur_r.fv};
      end
      STEP_TR: begin
        ram_addr = cur_r.addr + AW'(1);
        m1       = {1'b0, cur_r.fu};
      end
      default: begin
        ram_addr = cur_r.addr + AW'(cur_r.w) + AW'(1);
        m1       = {1'b0, cur_r.fu};
        m2       = {1'b0, cur_r.fv};
      end
    endcase
  end

  assign wt_prod   = {{FW{1'b0}}, m1} * {{FW{1'b0}}, m2};
  assign is_wr     = (cur_r.kind == K_WRITE);
  assign is_near   = (cur_r.kind == K_NEAR);
  assign done      = cur_valid_r && (is_wr || is_near || (k_r == STEP_BR));
  assign rd        = cur_valid_r && !is_wr;
  assign ram_we    = cur_valid_r && is_wr;
  assign ram_wdata = cur_r.texel;

  assign head_smp = (head.kind != K_WRITE);
  assign credit   = (rsv_r < RSV_W'(OUT_DEPTH));
  assign q_pop    = q_valid && (!cur_valid_r || done) && (!head_smp || credit);
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign rsv_nxt  = rsv_r + RSV_W'(q_pop && head_smp) - RSV_W'(out_xfer);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= head;
    end
    t_first_r <= (k_r == STEP_TL);
    t_last_r  <= done;
    t_wt_r    <= wt_prod[WTW-1:0];
  end

  // accumulate weighted components as the reads return
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]    = ACW'(t_wt_r) * ACW'(ram_rdata[TEXEL_W-1-COMP_W*c -: COMP_W]);
      acc_nxt[c] = t_first_r ? prod[c] : acc_r[c] + prod[c];
    end
  end

  always_ff @(posedge clk) begin
    if (t_valid_r) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
    end
  end

  // round to nearest, clamp
  always_comb begin
    rnd  = '0;
    val9 = '0;
    res  = '0;
    for (int c = 0; c < 3; c++) begin
      rnd  = acc_r[c] + HALF;
      val9 = rnd[ACW-1 -: 9];
      res[TEXEL_W-1-COMP_W*c -: COMP_W] = val9[8] ? 8'hFF : val9[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (done_r) begin
      ofifo_r[owp_r] <= res;
    end
  end

  assign ocnt_nxt           = ocnt_r + RSV_W'(done_r) - RSV_W'(out_xfer);
  assign out_chan.valid     = (ocnt_r != '0);
  assign out_chan.red_out   = ofifo_r[orp_r][TEXEL_W-1 -: COMP_W];
  assign out_chan.green_out = ofifo_r[orp_r][TEXEL_W-1-COMP_W -: COMP_W];
  assign out_chan.blue_out  = ofifo_r[orp_r][COMP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      k_r         <= STEP_TL;
      t_valid_r   <= 1'b0;
      done_r      <= 1'b0;
      owp_r       <= '0;
      orp_r       <= '0;
      ocnt_r      <= '0;
      rsv_r       <= '0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        k_r         <= STEP_TL;
      end else if (done) begin
        cur_valid_r <= 1'b0;
      end else if (cur_valid_r) begin
        k_r <= k_r + 2'd1;
      end
      t_valid_r <= rd;
      done_r    <= t_valid_r && t_last_r;
      if (done_r) begin
        owp_r <= owp_r + OP_W'(1);
      end
      if (out_xfer) begin
        orp_r <= orp_r + OP_W'(1);
      end
      ocnt_r <= ocnt_nxt;
      rsv_r  <= rsv_nxt;
    end
  end

endmodule
